[hdl/lscb_pkg.sv]
// Package for the LED status code blinker.
// Holds the sizing constants, register indexes and the phase encoding.
// No dependencies.
package lscb_pkg;

  localparam int CODE_BITS    = 4;
  localparam int REPEAT_COUNT = 3;
  localparam int PAUSE_GAPS   = 5;

  localparam int STATUS_W = 4;
  localparam int TICK_W   = 16;
  localparam int COUNT_W  = 19;
  localparam int BIT_W    = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam int REP_W    = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] SHORT_ON_RESET = TICK_W'(100);
  localparam logic [TICK_W-1:0] LONG_ON_RESET  = TICK_W'(300);
  localparam logic [TICK_W-1:0] GAP_RESET      = TICK_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_ON = 2'd0,
    REG_LONG_ON  = 2'd1,
    REG_GAP      = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ON    = 4'b0010,
    PH_GAP   = 4'b0100,
    PH_PAUSE = 4'b1000
  } phase_t;

  // Zero durations are stretched to a single tick.
  function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] v);
    return (v == '0) ? COUNT_W'(1) : v;
  endfunction

endpackage

[hdl/lscb_if.sv]
// Channel interfaces for the LED status code blinker.
// Depends on lscb_pkg for the field widths.
interface lscb_in_if import lscb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [STATUS_W-1:0] status_code;

  modport source (output valid, output mode, output status_code, input ready);
  modport sink   (input valid, input mode, input status_code, output ready);
endinterface

interface lscb_out_if;
  logic valid;
  logic ready;
  logic led_level;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (output valid, output led_level, output busy_res, output done_res,
                  output rejected, input ready);
  modport sink   (input valid, input led_level, input busy_res, input done_res,
                  input rejected, output ready);
endinterface

[hdl/led_status_code_blinker_core.sv]
// LED status code blinker: an accepted item's result is registered and shows in the
// cycle after; one item per cycle while the output side takes results. The phase
// counter and phase register update in the same cycle the item is accepted, and
// the result register decouples the output side. Synchronous active-high reset
// returns the timing registers to 100/300/200 ticks, the sequencer to idle with
// the LED off, and empties the result register.
module led_status_code_blinker_core
  import lscb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  lscb_in_if.sink              in_ch,
  lscb_out_if.source           out_ch
);

  logic [TICK_W-1:0]   short_on_ticks;
  logic [TICK_W-1:0]   long_on_ticks;
  logic [TICK_W-1:0]   gap_ticks;

  logic [STATUS_W-1:0] latched_code, latched_code_next;
  logic [REP_W-1:0]    repeat_index, repeat_index_next;
  logic [BIT_W-1:0]    bit_index, bit_index_next;
  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  phase_counter, phase_counter_next;
  logic                led_on, led_on_next;
  logic                done_next, rej_next;

  logic                out_valid;
  logic                in_accept;
  logic [COUNT_W-1:0]  count_dec;
  logic [COUNT_W-1:0]  gap_len, pause_len;
  logic [REP_W:0]      repeat_inc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  // On-time for the bit at idx of a given code; positions above the code read as zero.
  function automatic logic [COUNT_W-1:0] on_time(input logic [STATUS_W-1:0] code,
                                                 input logic [BIT_W-1:0]    idx);
    logic b;
    b = 1'b0;
    if (32'(idx) < STATUS_W) begin
      b = code[idx];
    end
    return at_least_one(b ? COUNT_W'(long_on_ticks) : COUNT_W'(short_on_ticks));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      short_on_ticks <= SHORT_ON_RESET;
      long_on_ticks  <= LONG_ON_RESET;
      gap_ticks      <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_ON: short_on_ticks <= cfg_data;
        REG_LONG_ON:  long_on_ticks  <= cfg_data;
        REG_GAP:      gap_ticks      <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign count_dec  = (phase_counter != '0) ? phase_counter - COUNT_W'(1) : '0;
  assign gap_len    = at_least_one(COUNT_W'(gap_ticks));
  assign pause_len  = at_least_one(COUNT_W'(gap_ticks) * COUNT_W'(PAUSE_GAPS));
  assign repeat_inc = {1'b0, repeat_index} + (REP_W+1)'(1);

  always_comb begin
    latched_code_next  = latched_code;
    repeat_index_next  = repeat_index;
    bit_index_next     = bit_index;
    phase_next         = phase;
    phase_counter_next = phase_counter;
    led_on_next        = led_on;
    done_next          = 1'b0;
    rej_next           = 1'b0;

    if (in_ch.mode) begin
      if (phase != PH_IDLE) begin
        rej_next = 1'b1;
      end else begin
        latched_code_next  = in_ch.status_code;
        repeat_index_next  = '0;
        bit_index_next     = BIT_W'(CODE_BITS - 1);
        phase_next         = PH_ON;
        led_on_next        = 1'b1;
        phase_counter_next = on_time(in_ch.status_code, BIT_W'(CODE_BITS - 1));
      end
    end else if (phase != PH_IDLE) begin
      phase_counter_next = count_dec;
      if (count_dec == '0) begin
        case (phase)
          PH_ON: begin
            led_on_next = 1'b0;
            if (bit_index != '0) begin
              phase_next         = PH_GAP;
              phase_counter_next = gap_len;
            end else begin
              phase_next         = PH_PAUSE;
              phase_counter_next = pause_len;
            end
          end
          PH_GAP: begin
            bit_index_next     = bit_index - BIT_W'(1);
            phase_next         = PH_ON;
            led_on_next        = 1'b1;
            phase_counter_next = on_time(latched_code, bit_index - BIT_W'(1));
          end
          PH_PAUSE: begin
            if (32'(repeat_inc) >= REPEAT_COUNT) begin
              phase_next         = PH_IDLE;
              led_on_next        = 1'b0;
              repeat_index_next  = '0;
              bit_index_next     = '0;
              phase_counter_next = '0;
              done_next          = 1'b1;
            end else begin
              repeat_index_next  = repeat_inc[REP_W-1:0];
              bit_index_next     = BIT_W'(CODE_BITS - 1);
              phase_next         = PH_ON;
              led_on_next        = 1'b1;
              phase_counter_next = on_time(latched_code, BIT_W'(CODE_BITS - 1));
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_code  <= '0;
      repeat_index  <= '0;
      bit_index     <= '0;
      phase         <= PH_IDLE;
      phase_counter <= '0;
      led_on        <= 1'b0;
    end else if (in_accept) begin
      latched_code  <= latched_code_next;
      repeat_index  <= repeat_index_next;
      bit_index     <= bit_index_next;
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      led_on        <= led_on_next;
    end
  end

  // Result register: loaded on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ch.led_level <= led_on_next;
      out_ch.busy_res  <= (phase_next != PH_IDLE);
      out_ch.done_res  <= done_next;
      out_ch.rejected  <= rej_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res && !out_ch.led_level)
    else $error("done result while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.rejected |-> out_ch.busy_res && !out_ch.done_res)
    else $error("rejected start without a sequence in progress");

  a_idle_led_off: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !led_on && (phase_counter == '0))
    else $error("LED or counter active while idle");

  a_start_lights: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_ch.mode && (phase == PH_IDLE)
      |=> out_ch.valid && out_ch.led_level && out_ch.busy_res && (phase == PH_ON))
    else $error("start from idle did not begin a pulse");

endmodule

[tb/tb_led_status_code_blinker_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for led_status_code_blinker_core: predicts the LED blink
// sequence in a small tracker class and checks every result transaction against it.
// Depends on lscb_pkg, the channel interfaces in lscb_if.sv and the core itself.
module tb_led_status_code_blinker_core import lscb_pkg::*; ();

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;
  // The index field has room for one register more than the block implements.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [TICK_W-1:0]    TICKS_MAX  = '1;
  localparam int unsigned          RANDOM_WORK = 900;

  typedef struct packed {
    logic led_level;
    logic busy_res;
    logic done_res;
    logic rejected;
  } blink_result_t;

  class blink_tracker;
    blink_result_t       led_results_due[$];
    logic [TICK_W-1:0]   short_on, long_on, gap;
    logic [STATUS_W-1:0] code;
    int unsigned         rep_idx, bit_idx;
    phase_t              phase;
    logic [COUNT_W-1:0]  ticks_left;
    logic                led;
    int unsigned         errors;
    int unsigned         work_items;

    function new();
      short_on   = SHORT_ON_RESET;
      long_on    = LONG_ON_RESET;
      gap        = GAP_RESET;
      code       = '0;
      rep_idx    = 0;
      bit_idx    = 0;
      phase      = PH_IDLE;
      ticks_left = '0;
      led        = 1'b0;
      errors     = 0;
      work_items = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
      case (idx)
        REG_SHORT_ON: short_on = data;
        REG_LONG_ON:  long_on  = data;
        REG_GAP:      gap      = data;
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] min_one(input logic [COUNT_W-1:0] v);
      return (v == '0) ? COUNT_W'(1) : v;
    endfunction

    function void start_pulse();
      logic code_bit;
      code_bit   = (bit_idx < STATUS_W) ? code[bit_idx] : 1'b0;
      phase      = PH_ON;
      led        = 1'b1;
      ticks_left = min_one(code_bit ? COUNT_W'(long_on) : COUNT_W'(short_on));
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return led_results_due.size();
    endfunction

    // Advances the sequencer by one accepted input transaction.
    function void take_item(input logic mode, input logic [STATUS_W-1:0] status);
      blink_result_t r;
      r = '0;
      if (mode == MODE_START) begin
        if (phase != PH_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          work_items++;
          code    = status;
          rep_idx = 0;
          bit_idx = CODE_BITS - 1;
          start_pulse();
        end
      end else if (phase != PH_IDLE) begin
        work_items++;
        if (ticks_left != '0) ticks_left--;
        if (ticks_left == '0) begin
          case (phase)
            PH_ON: begin
              led = 1'b0;
              if (bit_idx != 0) begin
                phase      = PH_GAP;
                ticks_left = min_one(COUNT_W'(gap));
              end else begin
                phase      = PH_PAUSE;
                ticks_left = min_one(COUNT_W'(gap) * COUNT_W'(PAUSE_GAPS));
              end
            end
            PH_GAP: begin
              bit_idx--;
              start_pulse();
            end
            default: begin
              rep_idx++;
              if (rep_idx >= REPEAT_COUNT) begin
                phase      = PH_IDLE;
                led        = 1'b0;
                rep_idx    = 0;
                bit_idx    = 0;
                ticks_left = '0;
                r.done_res = 1'b1;
              end else begin
                bit_idx = CODE_BITS - 1;
                start_pulse();
              end
            end
          endcase
        end
      end
      r.led_level = led;
      r.busy_res  = (phase != PH_IDLE);
      led_results_due.push_back(r);
    endfunction

    function void check_result(input blink_result_t got);
      blink_result_t want;
      if (led_results_due.size() == 0) begin
        $error("result transaction with no input transaction pending");
        errors++;
        return;
      end
      want = led_results_due.pop_front();
      if (got.led_level !== want.led_level) begin
        $error("led_level: expected %0b, actual %0b", want.led_level, got.led_level);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, actual %0b", want.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;
  bit                   idle_on;
  blink_tracker         tracker;

  lscb_in_if  in_ch ();
  lscb_out_if out_ch ();

  led_status_code_blinker_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) tracker.take_item(in_ch.mode, in_ch.status_code);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result({out_ch.led_level, out_ch.busy_res, out_ch.done_res,
                              out_ch.rejected});
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 35);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic mode, input logic [STATUS_W-1:0] status);
    while (idle_on && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.status_code <= status;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Ticks until the predicted sequence is over, with an occasional start that must bounce.
  task automatic finish_sequence();
    while (tracker.busy()) begin
      if ($urandom_range(99) < 4) send_item(MODE_START, STATUS_W'($urandom));
      else                        send_item(MODE_TICK, STATUS_W'($urandom));
    end
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers only change once all results are back.
  task automatic program_regs(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] l,
                              input logic [TICK_W-1:0] g, input bit poke_unused);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    @(negedge clk);
    write_one(REG_SHORT_ON, s);
    write_one(REG_LONG_ON, l);
    write_one(REG_GAP, g);
    if (poke_unused) write_one(REG_UNUSED, TICK_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(9))
      0:       return '0;
      8:       return TICK_W'($urandom_range(5, 12));
      default: return TICK_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.status_code = '0;
    idle_on           = 1'b1;
    tracker           = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset timing values, run back to back: a tick while idle, then the first short
    // pulse and gap up to one tick before the gap ends. Shorter values finish the rest.
    idle_on = 1'b0;
    send_item(MODE_TICK, 4'hF);
    send_item(MODE_START, 4'b0100);
    repeat (299) send_item(MODE_TICK, STATUS_W'($urandom));
    program_regs(TICK_W'(2), TICK_W'(3), TICK_W'(1), 1'b0);
    finish_sequence();
    idle_on = 1'b1;

    // Zero durations stretch to one tick; the unused index must not alias a register.
    program_regs('0, '0, '0, 1'b1);
    send_item(MODE_START, 4'b1010);
    send_item(MODE_START, 4'b0101);
    finish_sequence();
    send_item(MODE_START, 4'b0000);
    finish_sequence();
    send_item(MODE_TICK, 4'h0);

    program_regs(TICKS_MAX, TICK_W'(1), '0, 1'b0);
    send_item(MODE_START, 4'b1111);
    finish_sequence();

    while (tracker.work_items < RANDOM_WORK) begin
      idle_on = !(tracker.work_items > 500 && tracker.work_items < 700);
      program_regs(pick_ticks(), pick_ticks(), pick_ticks(), $urandom_range(3) == 0);
      repeat ($urandom_range(2)) send_item(MODE_TICK, STATUS_W'($urandom));
      send_item(MODE_START, STATUS_W'($urandom));
      finish_sequence();
      // A new start on the transaction right after the one that ends the sequence.
      if ($urandom_range(1)) begin
        send_item(MODE_START, STATUS_W'($urandom));
        finish_sequence();
      end
    end
    idle_on = 1'b1;

    // Largest timing values: the sequence is far too long to finish, so only its start runs.
    program_regs(TICKS_MAX, TICKS_MAX, TICKS_MAX, 1'b1);
    send_item(MODE_START, STATUS_W'($urandom));
    repeat (100) begin
      if ($urandom_range(99) < 4) send_item(MODE_START, STATUS_W'($urandom));
      else                        send_item(MODE_TICK, STATUS_W'($urandom));
    end
    in_ch.valid <= 1'b0;

    for (int n = 0; n < 2000 && tracker.pending() != 0; n++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("tb_led_status_code_blinker_core OK");
    end else begin
      $display("tb_led_status_code_blinker_core NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_led_status_code_blinker_core NOT OK");
    $finish;
  end

endmodule

[led_status_code_blinker_core.f]
hdl/lscb_pkg.sv
hdl/lscb_if.sv
hdl/led_status_code_blinker_core.sv
tb/tb_led_status_code_blinker_core.sv
